FILE: src/fbpa_pkg.sv
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// field widths, command and status codes, controller states, control/status structs
// no dependencies
`default_nettype none

package fbpa_pkg;

    // fixed field widths
    localparam int OFF_W       = 20;
    localparam int SIZE_W      = 13;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 3;
    localparam int LIMIT_W     = 5;
    localparam int CNT_OUT_W   = 9;
    localparam int CHK_OUT_W   = 5;
    localparam int CFG_IDX_W   = 1;

    // default geometry
    localparam int NODES_PER_CHUNK_DEF = 16;
    localparam int MAX_CHUNKS_DEF      = 16;

    // config register reset values
    localparam logic [SIZE_W-1:0]  NODE_BYTES_RST  = 13'd16;
    localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RST = 5'd16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_RANGE     = 3'd3,
        ST_MISALIGN  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RANGE,
        S_DIV,
        S_MAPRD,
        S_FREE,
        S_POPWAIT,
        S_MARK,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    latch_in;
        logic    clr_step;
        logic    stack_pop;
        logic    pop_load;
        logic    alloc_fresh;
        logic    alloc_chunk;
        logic    range_load;
        logic    div_start;
        logic    idx_from_div;
        logic    mark;
        logic    free_commit;
        logic    set_status;
        t_status status_code;
        logic    load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        t_cmd cmd;
        logic stack_nonempty;
        logic fresh_ok;
        logic chunk_ok;
        logic out_of_range;
        logic div_done;
        logic misaligned;
        logic map_bit;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: src/fbpa_div.sv
// fbpa_div: restoring divider, one quotient bit per cycle
// divides the node offset by the node size; uses fbpa_pkg widths
`default_nettype none

module fbpa_div
    import fbpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [OFF_W-1:0]  i_dividend,
    input  wire logic [SIZE_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [OFF_W-1:0]       o_quotient,
    output logic [SIZE_W-1:0]      o_remainder
);

    localparam int ITER_W = $clog2(OFF_W);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(OFF_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [OFF_W-1:0]  r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dvs;

    logic [OFF_W-1:0]  n_quo;
    logic [SIZE_W-1:0] n_rem;
    logic [SIZE_W:0]   w_trial;
    logic [SIZE_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[OFF_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_diff[SIZE_W-1:0];
            n_quo = {r_quo[OFF_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[SIZE_W-1:0];
            n_quo = {r_quo[OFF_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_ITER) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: src/fbpa_ctrl.sv
// fbpa_ctrl: sequencer of the pool allocator
// drives t_dp_cmd from state and t_dp_stat; uses fbpa_pkg
`default_nettype none

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_ALLOC: begin
                        if (i_stat.stack_nonempty)                    n_state = S_POPWAIT;
                        else if (i_stat.fresh_ok || i_stat.chunk_ok)  n_state = S_MARK;
                        else                                          n_state = S_DONE;
                    end
                    CMD_FREE, CMD_CHECK: n_state = S_RANGE;
                    default:             n_state = S_DONE;
                endcase
            end
            S_RANGE: begin
                n_state = i_stat.out_of_range ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    if (!i_stat.misaligned && i_stat.cmd == CMD_FREE) n_state = S_MAPRD;
                    else                                               n_state = S_DONE;
                end
            end
            S_MAPRD:   n_state = S_FREE;
            S_FREE:    n_state = S_DONE;
            S_POPWAIT: n_state = S_MARK;
            S_MARK:    n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.status_code = ST_OK;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE:  o_cmd.latch_in = i_in_valid;
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_ALLOC: begin
                        if (i_stat.stack_nonempty) begin
                            o_cmd.stack_pop = 1'b1;
                        end else if (i_stat.fresh_ok) begin
                            o_cmd.alloc_fresh = 1'b1;
                        end else if (i_stat.chunk_ok) begin
                            o_cmd.alloc_chunk = 1'b1;
                        end else begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_EXHAUSTED;
                        end
                    end
                    CMD_FREE, CMD_CHECK: o_cmd.range_load = 1'b1;
                    default: ;
                endcase
            end
            S_RANGE: begin
                if (i_stat.out_of_range) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_RANGE;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.misaligned) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_MISALIGN;
                    end else if (i_stat.cmd == CMD_FREE) begin
                        o_cmd.idx_from_div = 1'b1;
                    end
                end
            end
            S_FREE: begin
                if (!i_stat.map_bit) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_NOT_ALLOC;
                end else begin
                    o_cmd.free_commit = 1'b1;
                end
            end
            S_POPWAIT: o_cmd.pop_load = 1'b1;
            S_MARK:    o_cmd.mark     = 1'b1;
            S_DONE:    o_cmd.load_out = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: src/fbpa_dpath.sv
// fbpa_dpath: registers, allocated map, freed stack, divider and result register
// executes t_dp_cmd from fbpa_ctrl; uses fbpa_pkg and fbpa_div
`default_nettype none

module fbpa_dpath
    import fbpa_pkg::*;
#(
    parameter int NODES_PER_CHUNK = NODES_PER_CHUNK_DEF,
    parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_ctl,
    output t_dp_stat                   o_stat,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [OFF_W-1:0]      i_node_offset,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [SIZE_W-1:0]     i_cfg_data,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [STAT_W-1:0]          o_status,
    output logic [OFF_W-1:0]           o_granted_offset,
    output logic [CNT_OUT_W-1:0]       o_free_count,
    output logic [CNT_OUT_W-1:0]       o_allocated_count,
    output logic [CNT_OUT_W-1:0]       o_total_count,
    output logic [CHK_OUT_W-1:0]       o_chunks_in_use
);

    localparam int POOL_NODES = NODES_PER_CHUNK * MAX_CHUNKS;
    localparam int IDX_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int CNT_W  = $clog2(POOL_NODES + 1);
    localparam int CH_W   = $clog2(MAX_CHUNKS + 1);
    localparam int FR_W   = $clog2(NODES_PER_CHUNK + 1);
    localparam int LIM_W  = (CH_W > LIMIT_W) ? CH_W : LIMIT_W;
    localparam int GP_W   = (IDX_W + SIZE_W > OFF_W) ? IDX_W + SIZE_W : OFF_W;
    localparam int RP_W   = (CNT_W + SIZE_W > OFF_W) ? CNT_W + SIZE_W : OFF_W;
    localparam int CX_W   = CNT_W + CNT_OUT_W;
    localparam int HX_W   = CH_W + CHK_OUT_W;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(POOL_NODES - 1);
    localparam logic [CNT_W-1:0] POOL_CNT   = CNT_W'(POOL_NODES);
    localparam logic [CNT_W-1:0] NPC_CNT    = CNT_W'(NODES_PER_CHUNK);
    localparam logic [FR_W-1:0]  NPC_FR     = FR_W'(NODES_PER_CHUNK);
    localparam logic [CH_W-1:0]  MAX_CH     = CH_W'(MAX_CHUNKS);
    localparam logic [LIM_W-1:0] MAX_LIM    = LIM_W'(MAX_CHUNKS);

    // config
    logic [SIZE_W-1:0]  r_node_bytes;
    logic [LIMIT_W-1:0] r_chunk_limit;

    // per-item working registers
    t_cmd              r_cmd;
    logic [OFF_W-1:0]  r_off;
    t_status           r_status;
    logic [IDX_W-1:0]  r_idx;
    logic [RP_W-1:0]   r_range_prod;
    logic [OFF_W-1:0]  r_granted;

    // pool state
    logic [CNT_W-1:0]  r_depth;
    logic [CH_W-1:0]   r_chunks;
    logic [FR_W-1:0]   r_fresh;
    logic [CNT_W-1:0]  r_live;
    logic [IDX_W-1:0]  r_clr_addr;

    // memories
    logic              mem_map   [POOL_NODES];
    logic [IDX_W-1:0]  mem_stack [POOL_NODES];
    logic              r_map_rd;
    logic [IDX_W-1:0]  r_stack_rd;

    // result register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [OFF_W-1:0]     r_out_granted;
    logic [CNT_OUT_W-1:0] r_out_free;
    logic [CNT_OUT_W-1:0] r_out_live;
    logic [CNT_OUT_W-1:0] r_out_total;
    logic [CHK_OUT_W-1:0] r_out_chunks;

    logic [SIZE_W-1:0] w_size;
    logic [LIM_W-1:0]  w_eff_limit;
    logic [CNT_W-1:0]  w_total;
    logic [CNT_W-1:0]  w_free;
    logic [CNT_W-1:0]  w_fresh_full;
    logic [CNT_W-1:0]  w_depth_m1;
    logic [GP_W-1:0]   w_gprod;
    logic [RP_W-1:0]   w_rprod;
    logic [CX_W-1:0]   w_free_x;
    logic [CX_W-1:0]   w_live_x;
    logic [CX_W-1:0]   w_total_x;
    logic [HX_W-1:0]   w_chunks_x;
    logic [IDX_W-1:0]  w_map_addr;
    logic              w_map_we;
    logic              w_map_wdata;
    logic              w_push;
    logic              w_out_free;
    logic              w_div_done;
    logic [OFF_W-1:0]  w_quo;
    logic [SIZE_W-1:0] w_rem;

    always_comb begin
        w_size       = (r_node_bytes == '0) ? SIZE_W'(1) : r_node_bytes;
        w_eff_limit  = (LIM_W'(r_chunk_limit) > MAX_LIM) ? MAX_LIM : LIM_W'(r_chunk_limit);
        w_total      = CNT_W'(r_chunks) * NPC_CNT;
        w_free       = w_total - r_live;
        w_fresh_full = w_total - NPC_CNT + CNT_W'(r_fresh);
        w_depth_m1   = r_depth - 1'b1;
        w_gprod      = GP_W'(r_idx) * GP_W'(w_size);
        w_rprod      = RP_W'(w_total) * RP_W'(w_size);
        w_free_x     = CX_W'(w_free);
        w_live_x     = CX_W'(r_live);
        w_total_x    = CX_W'(w_total);
        w_chunks_x   = HX_W'(r_chunks);
        w_push       = i_ctl.free_commit && (r_depth < POOL_CNT);
        w_out_free   = !r_out_valid || !i_out_stall;
        w_map_addr   = i_ctl.clr_step ? r_clr_addr : r_idx;
        w_map_we     = i_ctl.clr_step || i_ctl.mark || i_ctl.free_commit;
        w_map_wdata  = i_ctl.mark;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_bytes  <= NODE_BYTES_RST;
            r_chunk_limit <= CHUNK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_BYTES:  r_node_bytes  <= i_cfg_data;
                CFG_CHUNK_LIMIT: r_chunk_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pool control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_chunks   <= '0;
            r_fresh    <= '0;
            r_live     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_ctl.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_ctl.stack_pop) r_depth <= w_depth_m1;
            if (w_push) r_depth <= r_depth + 1'b1;
            if (i_ctl.alloc_fresh) r_fresh <= r_fresh + 1'b1;
            if (i_ctl.alloc_chunk) begin
                r_chunks <= r_chunks + 1'b1;
                r_fresh  <= FR_W'(1);
            end
            if (i_ctl.mark) r_live <= r_live + 1'b1;
            if (i_ctl.free_commit && r_live != '0) r_live <= r_live - 1'b1;
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_off     <= i_node_offset;
            r_status  <= ST_OK;
            r_granted <= '0;
        end
        if (i_ctl.set_status) r_status <= i_ctl.status_code;
        if (i_ctl.alloc_fresh) r_idx <= w_fresh_full[IDX_W-1:0];
        if (i_ctl.alloc_chunk) r_idx <= w_total[IDX_W-1:0];
        if (i_ctl.pop_load) r_idx <= r_stack_rd;
        if (i_ctl.idx_from_div) r_idx <= w_quo[IDX_W-1:0];
        if (i_ctl.range_load) r_range_prod <= w_rprod;
        if (i_ctl.mark) r_granted <= w_gprod[OFF_W-1:0];
    end

    // allocated map, one port
    always_ff @(posedge i_clk) begin
        if (w_map_we) mem_map[w_map_addr] <= w_map_wdata;
        r_map_rd <= mem_map[w_map_addr];
    end

    // freed stack
    always_ff @(posedge i_clk) begin
        if (w_push) mem_stack[r_depth[IDX_W-1:0]] <= r_idx;
        if (i_ctl.stack_pop) r_stack_rd <= mem_stack[w_depth_m1[IDX_W-1:0]];
    end

    fbpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_ctl.div_start),
        .i_dividend  (r_off),
        .i_divisor   (w_size),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_status  <= r_status;
            r_out_granted <= r_granted;
            r_out_free    <= w_free_x[CNT_OUT_W-1:0];
            r_out_live    <= w_live_x[CNT_OUT_W-1:0];
            r_out_total   <= w_total_x[CNT_OUT_W-1:0];
            r_out_chunks  <= w_chunks_x[CHK_OUT_W-1:0];
        end
    end

    always_comb begin
        o_stat.clr_last       = (r_clr_addr == LAST_IDX);
        o_stat.cmd            = r_cmd;
        o_stat.stack_nonempty = (r_depth != '0);
        o_stat.fresh_ok       = (r_chunks != '0) && (r_fresh < NPC_FR);
        o_stat.chunk_ok       = (LIM_W'(r_chunks) < w_eff_limit);
        o_stat.out_of_range   = (RP_W'(r_off) >= r_range_prod);
        o_stat.div_done       = w_div_done;
        o_stat.misaligned     = (w_rem != '0);
        o_stat.map_bit        = r_map_rd;
        o_stat.out_free       = w_out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_offset  = r_out_granted;
    assign o_free_count      = r_out_free;
    assign o_allocated_count = r_out_live;
    assign o_total_count     = r_out_total;
    assign o_chunks_in_use   = r_out_chunks;

    a_live_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W+1)'(r_depth) + (CNT_W+1)'(r_live) <= (CNT_W+1)'(w_total))
        else $error("stacked plus live nodes exceed pool");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NPC_FR)
        else $error("fresh pointer beyond chunk");

    a_chunks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunks <= MAX_CH)
        else $error("chunk count beyond maximum");

endmodule

`default_nettype wire

FILE: src/fixed_block_pool_allocator_core.sv
// fixed_block_pool_allocator_core: top level of the fixed-size node pool allocator
// joins the fbpa_ctrl sequencer and the fbpa_dpath datapath; uses fbpa_pkg
// one item at a time, next accepted the cycle after its result loads; each passes
//   DECODE and DONE; alloc adds MARK for a fresh node and POPWAIT, MARK for a freed
//   node; free/check add RANGE, DIV unless out of range, MAPRD, FREE for aligned frees
// reset: synchronous; then a clearing pass over NODES_PER_CHUNK*MAX_CHUNKS entries
//   zeroes the allocated map, input held stalled meanwhile (config writes still taken)
`default_nettype none

module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int NODES_PER_CHUNK = NODES_PER_CHUNK_DEF,
    parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [SIZE_W-1:0]     i_cfg_data,
    // input item channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [OFF_W-1:0]      i_node_offset,
    // result item channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STAT_W-1:0]          o_status,
    output logic [OFF_W-1:0]           o_granted_offset,
    output logic [CNT_OUT_W-1:0]       o_free_count,
    output logic [CNT_OUT_W-1:0]       o_allocated_count,
    output logic [CNT_OUT_W-1:0]       o_total_count,
    output logic [CHK_OUT_W-1:0]       o_chunks_in_use
);

    // command and status buses between sequencer and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: clearing pass, decode, range check, divide, map update, result load
    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: pool counters, allocated map, LIFO of freed nodes,
    // divider and the output register that decouples the result side
    fbpa_dpath #(
        .NODES_PER_CHUNK (NODES_PER_CHUNK),
        .MAX_CHUNKS      (MAX_CHUNKS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_cmd),
        .o_stat            (w_stat),
        .i_cmd             (i_cmd),
        .i_node_offset     (i_node_offset),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_granted_offset  (o_granted_offset),
        .o_free_count      (o_free_count),
        .o_allocated_count (o_allocated_count),
        .o_total_count     (o_total_count),
        .o_chunks_in_use   (o_chunks_in_use)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for fixed_block_pool_allocator_core
// sends alloc/free/check items under random idling and back-pressure and checks every
// result against an in-bench model of the node pool; depends on fbpa_pkg and the rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fbpa_pkg::*;

    // geometry of the instance under test
    localparam int NPC  = NODES_PER_CHUNK_DEF;
    localparam int MAXC = MAX_CHUNKS_DEF;
    localparam int POOL = NPC * MAXC;

    // bench timing
    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 12;
    localparam int IDLE_PCT     = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 400000;

    // ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [SIZE_W-1:0]    i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_cmd         = CMD_NONE;
    logic [OFF_W-1:0]     i_node_offset = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [OFF_W-1:0]     o_granted_offset;
    logic [CNT_OUT_W-1:0] o_free_count;
    logic [CNT_OUT_W-1:0] o_allocated_count;
    logic [CNT_OUT_W-1:0] o_total_count;
    logic [CHK_OUT_W-1:0] o_chunks_in_use;

    // one predicted result item
    typedef struct {
        t_status              status;
        logic [OFF_W-1:0]     granted;
        logic [CNT_OUT_W-1:0] free_cnt;
        logic [CNT_OUT_W-1:0] alloc_cnt;
        logic [CNT_OUT_W-1:0] total_cnt;
        logic [CHK_OUT_W-1:0] chunks;
    } t_pool_result;

    t_pool_result expected_results [$];

    // pool model state, mirrors the block after each accepted item
    bit                 node_busy [POOL];
    int                 freed_lifo [POOL];
    int                 lifo_depth      = 0;
    int                 chunk_cnt       = 0;
    int                 fresh_idx       = 0;
    int                 live_nodes      = 0;
    logic [SIZE_W-1:0]  node_bytes_reg  = NODE_BYTES_RST;
    logic [LIMIT_W-1:0] chunk_limit_reg = CHUNK_LIMIT_RST;

    // bench control and bookkeeping
    bit      quiet           = 1'b0;
    int      hold_req        = 0;
    int      hold_ack        = 0;
    int      hold_left       = 0;
    int      cycle_count     = 0;
    int      mismatches      = 0;
    int      items_sent      = 0;
    int      results_checked = 0;
    int      status_seen [8] = '{default: 0};
    t_status last_status     = ST_OK;

    fixed_block_pool_allocator_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_node_offset    (i_node_offset),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_free_count     (o_free_count),
        .o_allocated_count(o_allocated_count),
        .o_total_count    (o_total_count),
        .o_chunks_in_use  (o_chunks_in_use)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL fixed_block_pool_allocator_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pool model
    // ------------------------------------------------------------------

    // a node size of zero behaves as one byte
    function automatic longint eff_node_bytes();
        return (node_bytes_reg == '0) ? 64'd1 : longint'(node_bytes_reg);
    endfunction

    // limit saturates at the number of chunks the pool can hold
    function automatic int chunk_cap();
        return (chunk_limit_reg > MAXC) ? MAXC : int'(chunk_limit_reg);
    endfunction

    // byte offset of a node, wrapped to the offset width
    function automatic logic [OFF_W-1:0] node_offset_of(input int idx);
        longint off_l;
        off_l = longint'(idx) * eff_node_bytes();
        return off_l[OFF_W-1:0];
    endfunction

    // range first, then alignment; idx valid only on ok
    function automatic t_status locate_node(input logic [OFF_W-1:0] off, output int idx);
        longint span;
        span = longint'(chunk_cnt) * NPC * eff_node_bytes();
        idx  = 0;
        if (longint'(off) >= span)
            return ST_RANGE;
        if (longint'(off) % eff_node_bytes() != 0)
            return ST_MISALIGN;
        idx = int'(longint'(off) / eff_node_bytes());
        return ST_OK;
    endfunction

    // apply one item to the model and return the result it must produce
    function automatic t_pool_result pool_step(input t_cmd op, input logic [OFF_W-1:0] off);
        t_pool_result r;
        int           idx;
        bit           got;
        r.status  = ST_OK;
        r.granted = '0;
        idx       = 0;
        got       = 1'b0;
        case (op)
            CMD_ALLOC: begin
                // freed nodes first (lifo), then fresh nodes, then a new chunk
                if (lifo_depth > 0) begin
                    lifo_depth--;
                    idx = freed_lifo[lifo_depth];
                    got = 1'b1;
                end else if (chunk_cnt > 0 && fresh_idx < NPC) begin
                    idx = (chunk_cnt - 1) * NPC + fresh_idx;
                    fresh_idx++;
                    got = 1'b1;
                end else if (chunk_cnt < chunk_cap()) begin
                    chunk_cnt++;
                    idx       = (chunk_cnt - 1) * NPC;
                    fresh_idx = 1;
                    got       = 1'b1;
                end
                if (got && idx < POOL) begin
                    node_busy[idx] = 1'b1;
                    live_nodes++;
                    r.granted = node_offset_of(idx);
                end else begin
                    r.status = ST_EXHAUSTED;
                end
            end
            CMD_FREE: begin
                r.status = locate_node(off, idx);
                if (r.status == ST_OK) begin
                    if (idx >= POOL || !node_busy[idx]) begin
                        // double free or never handed out: nothing changes
                        r.status = ST_NOT_ALLOC;
                    end else begin
                        node_busy[idx] = 1'b0;
                        if (lifo_depth < POOL) begin
                            freed_lifo[lifo_depth] = idx;
                            lifo_depth++;
                        end
                        if (live_nodes > 0)
                            live_nodes--;
                    end
                end
            end
            CMD_CHECK: r.status = locate_node(off, idx);
            default: ;  // unused command reports ok and changes nothing
        endcase
        r.total_cnt = CNT_OUT_W'(chunk_cnt * NPC);
        r.alloc_cnt = CNT_OUT_W'(live_nodes);
        r.free_cnt  = CNT_OUT_W'(chunk_cnt * NPC - live_nodes);
        r.chunks    = CHK_OUT_W'(chunk_cnt);
        return r;
    endfunction

    // some node the model holds as allocated, -1 when none
    function automatic int pick_live_node();
        int total;
        int start;
        total = chunk_cnt * NPC;
        if (live_nodes == 0 || total == 0)
            return -1;
        start = $urandom_range(total - 1);
        for (int k = 0; k < total; k++)
            if (node_busy[(start + k) % total])
                return (start + k) % total;
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall, long hold-off on request, and checking
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            // a test asked for a long hold-off
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function automatic void check_result();
        t_pool_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            $error("result item with nothing expected: status %0d", o_status);
            return;
        end
        want = expected_results.pop_front();
        compare_field("status", want.status, o_status);
        compare_field("granted_offset", want.granted, o_granted_offset);
        compare_field("free_count", want.free_cnt, o_free_count);
        compare_field("allocated_count", want.alloc_cnt, o_allocated_count);
        compare_field("total_count", want.total_cnt, o_total_count);
        compare_field("chunks_in_use", want.chunks, o_chunks_in_use);
        results_checked++;
        status_seen[want.status]++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            check_result();
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // entered and left at a falling edge; valid drops at the falling edge after the
    // accept so an accepted payload is never offered again
    task automatic send_item(input t_cmd op, input logic [OFF_W-1:0] off);
        t_pool_result want;
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= op;
        i_node_offset <= off;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want        = pool_step(op, off);
        last_status = want.status;
        expected_results.push_back(want);
        items_sent++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // only called with no item in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_NODE_BYTES)
            node_bytes_reg = value[SIZE_W-1:0];
        else
            chunk_limit_reg = value[LIMIT_W-1:0];
    endtask

    task automatic set_pool_config(input int unsigned nbytes, input int unsigned limit);
        write_reg(CFG_NODE_BYTES, nbytes);
        write_reg(CFG_CHUNK_LIMIT, limit);
    endtask

    task automatic free_live_node();
        int idx;
        idx = pick_live_node();
        if (idx < 0)
            idx = 0;
        send_item(CMD_FREE, node_offset_of(idx));
    endtask

    // allocs, frees, checks, no-ops: live nodes, double frees, misaligned, out-of-range, raw
    task automatic send_random_item(input int alloc_pct);
        int unsigned sel;
        int          idx;
        int          total;
        longint      off_l;
        t_cmd        op;
        if ($urandom_range(99) < alloc_pct) begin
            send_item(CMD_ALLOC, OFF_W'($urandom));
            return;
        end
        sel = $urandom_range(99);
        if (sel < 70)
            op = CMD_FREE;
        else if (sel < 95)
            op = CMD_CHECK;
        else
            op = CMD_NONE;
        total = chunk_cnt * NPC;
        sel   = $urandom_range(99);
        if (sel < 70) begin
            idx = pick_live_node();
            if (idx < 0)
                idx = (total > 0) ? $urandom_range(total - 1) : 0;
            off_l = longint'(idx) * eff_node_bytes();
        end else if (sel < 80) begin
            // any node in range, often already free
            idx   = (total > 0) ? $urandom_range(total - 1) : 0;
            off_l = longint'(idx) * eff_node_bytes();
        end else if (sel < 88) begin
            idx   = (total > 0) ? $urandom_range(total - 1) : 0;
            off_l = longint'(idx) * eff_node_bytes()
                    + $urandom_range(int'(eff_node_bytes()) - 1);
        end else if (sel < 95) begin
            off_l = longint'(total) * eff_node_bytes() + $urandom_range(1000);
        end else begin
            off_l = $urandom;
        end
        send_item(op, OFF_W'(off_l));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty pool, zero limit, saturated limit, zero node size, double free, lifo reuse,
    // range before alignment, node size changed with nodes out
    task automatic test_directed_cases();
        set_pool_config(16, 0);
        send_item(CMD_ALLOC, '1);
        send_item(CMD_CHECK, '0);
        send_item(CMD_FREE, '0);
        send_item(CMD_NONE, '1);
        wait_results_done();
        set_pool_config(0, 31);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, OFF_W'(1));
        send_item(CMD_FREE, OFF_W'(1));
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, OFF_W'(5));
        send_item(CMD_CHECK, OFF_W'(15));
        send_item(CMD_CHECK, OFF_W'(16));
        wait_results_done();
        write_reg(CFG_NODE_BYTES, 4096);
        send_item(CMD_CHECK, OFF_W'(3));
        send_item(CMD_CHECK, OFF_W'(4096));
        send_item(CMD_CHECK, '1);
        send_item(CMD_FREE, OFF_W'(1));
        send_item(CMD_FREE, OFF_W'(8192));
        wait_results_done();
        write_reg(CFG_NODE_BYTES, 8191);
        send_item(CMD_FREE, OFF_W'(8191));
        send_item(CMD_ALLOC, '0);
        wait_results_done();
    endtask

    // no random input idling and no random output stall
    task automatic test_streaming();
        set_pool_config(16, 16);
        quiet <= 1'b1;
        repeat (100) send_random_item(50);
        wait_results_done();
        quiet <= 1'b0;
    endtask

    // output held off for a long stretch while items keep coming
    task automatic test_output_holdoff();
        hold_req <= hold_req + 1;
        repeat (20) send_random_item(60);
        wait_results_done();
    endtask

    // phases with different settings; the first lowers the limit below the chunks added
    task automatic test_random_settings();
        int unsigned nbytes;
        int unsigned limit;
        int          pct;
        for (int phase = 0; phase < 6; phase++) begin
            wait_results_done();
            case ($urandom_range(5))
                0:       nbytes = 0;
                1:       nbytes = 1;
                2:       nbytes = 4096;
                3:       nbytes = 8191;
                4:       nbytes = 1 << $urandom_range(6);
                default: nbytes = $urandom_range(4096, 1);
            endcase
            case ($urandom_range(5))
                0:       limit = 0;
                1:       limit = 1;
                2:       limit = 2;
                3:       limit = 16;
                4:       limit = 31;
                default: limit = $urandom_range(31);
            endcase
            if (phase == 0) begin
                nbytes = 1;
                limit  = 0;
            end else if (phase == 1) begin
                nbytes = 4096;
                limit  = 31;
            end
            case ($urandom_range(2))
                0:       pct = 25;
                1:       pct = 50;
                default: pct = 75;
            endcase
            set_pool_config(nbytes, limit);
            repeat (80) send_random_item(pct);
        end
        wait_results_done();
    endtask

    // fill the whole pool with wide nodes so offsets wrap, run dry, shrink the limit,
    // then change node size with nodes out and free everything
    task automatic test_pool_exhaustion();
        int guard;
        set_pool_config(8191, 16);
        guard = 0;
        do begin
            send_item(CMD_ALLOC, OFF_W'($urandom));
            guard++;
        end while (last_status != ST_EXHAUSTED && guard < POOL + 4);
        repeat (40) free_live_node();
        wait_results_done();
        write_reg(CFG_CHUNK_LIMIT, 3);
        repeat (45) send_item(CMD_ALLOC, OFF_W'($urandom));
        wait_results_done();
        write_reg(CFG_NODE_BYTES, 16);
        guard = 0;
        while (live_nodes > 0 && guard < POOL + 4) begin
            free_live_node();
            guard++;
        end
        wait_results_done();
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_streaming();
        test_output_holdoff();
        test_random_settings();
        test_pool_exhaustion();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d results: ", items_sent, results_checked,
                 "%0d ok, %0d exhausted, %0d not allocated, ",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_NOT_ALLOC],
                 "%0d out of range, %0d misaligned",
                 status_seen[ST_RANGE], status_seen[ST_MISALIGN]);
        $display("node sizes 0 to 8191, chunk limits 0 to 31, full pool, %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS fixed_block_pool_allocator_core");
        else
            $display("FAIL fixed_block_pool_allocator_core");
        $finish;
    end

endmodule

FILE: filelist.f
src/fbpa_pkg.sv
src/fbpa_div.sv
src/fbpa_ctrl.sv
src/fbpa_dpath.sv
src/fixed_block_pool_allocator_core.sv
tb/sv/testbench.sv
